// ===== rtl/spc_pkg.sv =====
`default_nettype none

package spc_pkg;

  // Pair kinds on the input channel.
  localparam logic [1:0] OP_CC = 2'd0;
  localparam logic [1:0] OP_BB = 2'd1;
  localparam logic [1:0] OP_CB = 2'd2;

  // Work kinds handed from the front end to the back end.
  localparam logic [1:0] KIND_FIXED = 2'd0;
  localparam logic [1:0] KIND_CC    = 2'd1;
  localparam logic [1:0] KIND_CB    = 2'd2;

  localparam int ROOT_W = 33;
  localparam int QUO_W  = 17;

  localparam logic signed [17:0] UNIT_POS = 18'sd65536;
  localparam logic signed [17:0] UNIT_NEG = -18'sd65536;

  localparam logic signed [36:0] DEPTH_MAX = 37'sd2147483647;
  localparam logic signed [36:0] DEPTH_MIN = -37'sd2147483648;

  typedef struct packed {
    logic [1:0]         op;
    logic [30:0]        aw;
    logic [30:0]        ah;
    logic [30:0]        bw;
    logic [30:0]        bh;
    logic signed [32:0] cc_dx;
    logic signed [32:0] cc_dy;
    logic signed [35:0] bb_dx2;
    logic signed [35:0] bb_dy2;
    logic signed [35:0] cb_dx;
    logic signed [35:0] cb_dy;
    logic signed [35:0] cb_xm;
    logic signed [35:0] cb_xp;
    logic signed [35:0] cb_ym;
    logic signed [35:0] cb_yp;
  } spc_diff_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic               hit;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic signed [31:0] depth;
    logic [32:0]        mag_x;
    logic [32:0]        mag_y;
    logic               neg_x;
    logic               neg_y;
    logic [31:0]        radius;
    logic [30:0]        aw;
  } spc_carry_t;

  typedef struct packed {
    spc_carry_t  carry;
    logic [65:0] sq;
  } spc_job_t;

  typedef struct packed {
    spc_carry_t  carry;
    logic [66:0] rem;
    logic [66:0] root;
  } spc_root_t;

  typedef struct packed {
    logic               use_div;
    logic               hit;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic signed [31:0] depth;
    logic               neg_x;
    logic               neg_y;
    logic [32:0]        divisor;
    logic [49:0]        rem_x;
    logic [49:0]        rem_y;
    logic [16:0]        q_x;
    logic [16:0]        q_y;
  } spc_div_t;

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    if (v > DEPTH_MAX) begin
      return DEPTH_MAX[31:0];
    end else if (v < DEPTH_MIN) begin
      return DEPTH_MIN[31:0];
    end
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/spc_if.sv =====
`default_nettype none

interface spc_pair_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic [30:0]        a_width_or_radius;
  logic [30:0]        a_height;
  logic signed [31:0] b_x;
  logic signed [31:0] b_y;
  logic [30:0]        b_width_or_radius;
  logic [30:0]        b_height;

  modport source (
    output valid, operation, a_x, a_y, a_width_or_radius, a_height,
           b_x, b_y, b_width_or_radius, b_height,
    input  ready
  );
  modport sink (
    input  valid, operation, a_x, a_y, a_width_or_radius, a_height,
           b_x, b_y, b_width_or_radius, b_height,
    output ready
  );
endinterface

interface spc_contact_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [17:0] normal_x;
  logic signed [17:0] normal_y;
  logic signed [31:0] depth;

  modport source (output valid, hit, normal_x, normal_y, depth, input ready);
  modport sink (input valid, hit, normal_x, normal_y, depth, output ready);
endinterface

`default_nettype wire

// ===== rtl/shape_pair_contact_unit.sv =====
// Shape pair contact unit.
// The pair channel takes one shape pair per transaction: circle-circle,
// box-box or circle A with box B, coordinates in signed Q16.16. The contact
// channel returns exactly one transaction per pair, in order: hit flag, unit
// normal pointing from B toward A, and penetration depth.
// Throughput is one pair per cycle when nothing stalls. From the accepting edge a
// pair passes the first front stage, which loads at that edge, two more front
// stages, the queue, 33 square-root stages (one root bit each), one decision
// stage, 17 division stages (one quotient bit each) and the output register.
// The front end and the back end are joined by a small queue, so the front
// keeps accepting pairs while the back end is held.
// When the contact receiver stalls, the whole back end holds; once the queue
// is full and the last front stage holds a pair, pair ready drops until the
// receiver takes a transaction.
// Reset (rst, synchronous) empties every stage and the queue; pair ready is
// high in the first cycle after reset.
`default_nettype none

module shape_pair_contact_unit import spc_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  spc_pair_if.sink      pair,
  spc_contact_if.source contact
);

  logic     f_valid, f_ready;
  logic     b_valid, b_ready;
  spc_job_t f_job, b_job;

  spc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pair      (pair),
    .job_valid (f_valid),
    .job       (f_job),
    .job_ready (f_ready)
  );

  spc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_job   (f_job),
    .push_ready (f_ready),
    .pop_valid  (b_valid),
    .pop_job    (b_job),
    .pop_ready  (b_ready)
  );

  spc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (b_valid),
    .job       (b_job),
    .job_ready (b_ready),
    .contact   (contact)
  );

endmodule

`default_nettype wire

// ===== rtl/spc_front.sv =====
`default_nettype none

module spc_front import spc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  spc_pair_if.sink  pair,
  output logic      job_valid,
  output spc_job_t  job,
  input  logic      job_ready
);

  logic       v1, v2, v3;
  logic       adv;
  spc_diff_t  s1, s1_next;
  spc_carry_t s2, s2_next;
  spc_job_t   s3, s3_next;

  assign adv        = !v3 || job_ready;
  assign pair.ready = adv;
  assign job_valid  = v3;
  assign job        = s3;

  // Stage 1: coordinate differences. Box-related offsets are in half-LSB units.
  always_comb begin : diff
    logic signed [35:0] ax2, ay2, bx2, by2;
    ax2 = {{3{pair.a_x[31]}}, pair.a_x, 1'b0};
    ay2 = {{3{pair.a_y[31]}}, pair.a_y, 1'b0};
    bx2 = {{3{pair.b_x[31]}}, pair.b_x, 1'b0};
    by2 = {{3{pair.b_y[31]}}, pair.b_y, 1'b0};
    s1_next.op     = pair.operation;
    s1_next.aw     = pair.a_width_or_radius;
    s1_next.ah     = pair.a_height;
    s1_next.bw     = pair.b_width_or_radius;
    s1_next.bh     = pair.b_height;
    s1_next.cc_dx  = {pair.a_x[31], pair.a_x} - {pair.b_x[31], pair.b_x};
    s1_next.cc_dy  = {pair.a_y[31], pair.a_y} - {pair.b_y[31], pair.b_y};
    s1_next.cb_dx  = bx2 + {5'b0, pair.b_width_or_radius} - ax2;
    s1_next.cb_dy  = by2 + {5'b0, pair.b_height} - ay2;
    s1_next.bb_dx2 = bx2 + {5'b0, pair.b_width_or_radius} - ax2
                     - {5'b0, pair.a_width_or_radius};
    s1_next.bb_dy2 = by2 + {5'b0, pair.b_height} - ay2 - {5'b0, pair.a_height};
    s1_next.cb_xm  = bx2 - ax2;
    s1_next.cb_xp  = bx2 + {4'b0, pair.b_width_or_radius, 1'b0} - ax2;
    s1_next.cb_ym  = by2 - ay2;
    s1_next.cb_yp  = by2 + {4'b0, pair.b_height, 1'b0} - ay2;
  end

  // Stage 2: classify the pair. Results that need no square root are finished here.
  always_comb begin : classify
    logic [35:0]        abs_bx, abs_by, abs_cx, abs_cy, abs_ex, abs_ey, abs_n;
    logic signed [36:0] xo, yo, dep;
    logic signed [35:0] bw_s, bh_s, ex, ey, n;
    logic               x_axis, in_box;
    s2_next    = '0;
    s2_next.aw = s1.aw;
    bw_s   = $signed({5'b0, s1.bw});
    bh_s   = $signed({5'b0, s1.bh});
    abs_bx = s1.bb_dx2[35] ? -s1.bb_dx2 : s1.bb_dx2;
    abs_by = s1.bb_dy2[35] ? -s1.bb_dy2 : s1.bb_dy2;
    abs_cx = s1.cb_dx[35] ? -s1.cb_dx : s1.cb_dx;
    abs_cy = s1.cb_dy[35] ? -s1.cb_dy : s1.cb_dy;
    xo = ($signed({6'b0, s1.aw}) + $signed({6'b0, s1.bw}) - $signed({1'b0, abs_bx})) >>> 1;
    yo = ($signed({6'b0, s1.ah}) + $signed({6'b0, s1.bh}) - $signed({1'b0, abs_by})) >>> 1;
    in_box = (s1.cb_dx <= bw_s) && (s1.cb_dx >= -bw_s) &&
             (s1.cb_dy <= bh_s) && (s1.cb_dy >= -bh_s);
    x_axis = abs_cx > abs_cy;
    if (x_axis) begin
      n = (s1.cb_dx > 36'sd0) ? s1.cb_xm : s1.cb_xp;
    end else begin
      n = (s1.cb_dy > 36'sd0) ? s1.cb_ym : s1.cb_yp;
    end
    abs_n = n[35] ? -n : n;
    dep   = $signed({6'b0, s1.aw}) - $signed({2'b0, abs_n[35:1]});
    ex = (s1.cb_dx > bw_s) ? s1.cb_xm : ((s1.cb_dx < -bw_s) ? s1.cb_xp : '0);
    ey = (s1.cb_dy > bh_s) ? s1.cb_ym : ((s1.cb_dy < -bh_s) ? s1.cb_yp : '0);
    abs_ex = ex[35] ? -ex : ex;
    abs_ey = ey[35] ? -ey : ey;
    case (s1.op)
      OP_CC: begin
        s2_next.kind   = KIND_CC;
        s2_next.mag_x  = s1.cc_dx[32] ? -s1.cc_dx : s1.cc_dx;
        s2_next.mag_y  = s1.cc_dy[32] ? -s1.cc_dy : s1.cc_dy;
        s2_next.neg_x  = s1.cc_dx[32];
        s2_next.neg_y  = s1.cc_dy[32];
        s2_next.radius = {1'b0, s1.aw} + {1'b0, s1.bw};
      end
      OP_BB: begin
        if (xo > 37'sd0 && yo > 37'sd0) begin
          s2_next.hit = 1'b1;
          if (xo < yo) begin
            s2_next.nx    = s1.bb_dx2[35] ? UNIT_POS : UNIT_NEG;
            s2_next.depth = xo[31:0];
          end else begin
            s2_next.ny    = s1.bb_dy2[35] ? UNIT_POS : UNIT_NEG;
            s2_next.depth = yo[31:0];
          end
        end
      end
      OP_CB: begin
        if (in_box) begin
          // Centre inside the box: push out through the nearest face.
          s2_next.hit   = 1'b1;
          s2_next.depth = sat32(dep);
          if (n == 36'sd0) begin
            s2_next.nx = UNIT_POS;
          end else if (x_axis) begin
            s2_next.nx = n[35] ? UNIT_NEG : UNIT_POS;
          end else begin
            s2_next.ny = n[35] ? UNIT_NEG : UNIT_POS;
          end
        end else if (abs_ex <= {4'b0, s1.aw, 1'b0} && abs_ey <= {4'b0, s1.aw, 1'b0}) begin
          s2_next.kind   = KIND_CB;
          s2_next.mag_x  = abs_ex[32:0];
          s2_next.mag_y  = abs_ey[32:0];
          s2_next.neg_x  = ex > 36'sd0;
          s2_next.neg_y  = ey > 36'sd0;
          s2_next.radius = {s1.aw, 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  // Stage 3: squared length. A magnitude of exactly 2^32 squares to 2^64.
  always_comb begin : square
    logic [63:0] px, py;
    logic [64:0] sx, sy;
    px = s2.mag_x[31:0] * s2.mag_x[31:0];
    py = s2.mag_y[31:0] * s2.mag_y[31:0];
    sx = s2.mag_x[32] ? {1'b1, 64'b0} : {1'b0, px};
    sy = s2.mag_y[32] ? {1'b1, 64'b0} : {1'b0, py};
    s3_next.carry = s2;
    s3_next.sq    = {1'b0, sx} + {1'b0, sy};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= pair.valid;
      v2 <= v1;
      v3 <= v2;
    end
    if (adv) begin
      s1 <= s1_next;
      s2 <= s2_next;
      s3 <= s3_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/spc_queue.sv =====
`default_nettype none

module spc_queue import spc_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  input  spc_job_t push_job,
  output logic     push_ready,
  output logic     pop_valid,
  output spc_job_t pop_job,
  input  logic     pop_ready
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  spc_job_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push, pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_job    = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not rise on push");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> count == $past(count) - 1'b1)
    else $error("queue count did not fall on pop");

endmodule

`default_nettype wire

// ===== rtl/spc_back.sv =====
`default_nettype none

module spc_back import spc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  input  spc_job_t      job,
  output logic          job_ready,
  spc_contact_if.source contact
);

  logic                adv;
  spc_root_t           rs [ROOT_W];
  logic [ROOT_W-1:0]   rv;
  spc_div_t            dreg, dreg_next;
  logic                dreg_v;
  spc_div_t            ds [QUO_W];
  logic [QUO_W-1:0]    dsv;
  spc_root_t           rlast;
  spc_div_t            dlast;

  assign adv       = !contact.valid || contact.ready;
  assign job_ready = adv;

  // Square root, one result bit per stage, most significant first.
  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    localparam int SH = 2 * (ROOT_W - 1 - k);
    spc_root_t   src, nxt;
    logic        src_v;
    logic [66:0] trial;
    if (k == 0) begin : g_head
      assign src   = '{carry: job.carry, rem: {1'b0, job.sq}, root: '0};
      assign src_v = job_valid;
    end else begin : g_body
      assign src   = rs[k-1];
      assign src_v = rv[k-1];
    end
    always_comb begin
      trial = src.root + (67'd1 << SH);
      nxt   = src;
      if (src.rem >= trial) begin
        nxt.rem  = src.rem - trial;
        nxt.root = (src.root >> 1) + (67'd1 << SH);
      end else begin
        nxt.root = src.root >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        rv[k] <= 1'b0;
      end else if (adv) begin
        rv[k] <= src_v;
      end
      if (adv) begin
        rs[k] <= nxt;
      end
    end
  end

  assign rlast = rs[ROOT_W-1];

  // Hit test against the length and setup of the two normal divisions.
  always_comb begin : decide
    logic [32:0]        d;
    logic signed [36:0] dep;
    spc_carry_t         c;
    c   = rlast.carry;
    d   = rlast.root[32:0];
    dep = '0;
    dreg_next         = '0;
    dreg_next.hit     = c.hit;
    dreg_next.nx      = c.nx;
    dreg_next.ny      = c.ny;
    dreg_next.depth   = c.depth;
    dreg_next.neg_x   = c.neg_x;
    dreg_next.neg_y   = c.neg_y;
    dreg_next.divisor = d;
    dreg_next.rem_x   = {1'b0, c.mag_x, 16'b0};
    dreg_next.rem_y   = {1'b0, c.mag_y, 16'b0};
    case (c.kind)
      KIND_CC: begin
        if ({1'b0, c.radius} > d) begin
          dreg_next.hit = 1'b1;
          if (d == '0) begin
            // Coincident centres: fixed normal along x, depth is A's radius.
            dreg_next.nx    = UNIT_POS;
            dreg_next.depth = {1'b0, c.aw};
          end else begin
            dep = $signed({5'b0, c.radius}) - $signed({4'b0, d});
            dreg_next.use_div = 1'b1;
            dreg_next.depth   = sat32(dep);
          end
        end
      end
      KIND_CB: begin
        // The squared length must not exceed the squared radius, so a root equal
        // to the radius only counts when nothing is left over.
        if (d < {1'b0, c.radius} || (d == {1'b0, c.radius} && rlast.rem == '0)) begin
          dep = $signed({6'b0, c.aw}) - $signed({5'b0, d[32:1]});
          dreg_next.hit     = 1'b1;
          dreg_next.use_div = 1'b1;
          dreg_next.depth   = sat32(dep);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dreg_v <= 1'b0;
    end else if (adv) begin
      dreg_v <= rv[ROOT_W-1];
    end
    if (adv) begin
      dreg <= dreg_next;
    end
  end

  // Restoring division for both normal components, one quotient bit per stage.
  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    localparam int SH = QUO_W - 1 - j;
    spc_div_t    src, nxt;
    logic        src_v;
    logic [49:0] trial;
    if (j == 0) begin : g_head
      assign src   = dreg;
      assign src_v = dreg_v;
    end else begin : g_body
      assign src   = ds[j-1];
      assign src_v = dsv[j-1];
    end
    always_comb begin
      trial = {17'b0, src.divisor} << SH;
      nxt   = src;
      if (src.rem_x >= trial) begin
        nxt.rem_x   = src.rem_x - trial;
        nxt.q_x[SH] = 1'b1;
      end
      if (src.rem_y >= trial) begin
        nxt.rem_y   = src.rem_y - trial;
        nxt.q_y[SH] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dsv[j] <= 1'b0;
      end else if (adv) begin
        dsv[j] <= src_v;
      end
      if (adv) begin
        ds[j] <= nxt;
      end
    end
  end

  assign dlast = ds[QUO_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      contact.valid <= 1'b0;
    end else if (adv) begin
      contact.valid <= dsv[QUO_W-1];
    end
    if (adv) begin
      contact.hit   <= dlast.hit;
      contact.depth <= dlast.depth;
      if (dlast.use_div) begin
        contact.normal_x <= dlast.neg_x ? -$signed({1'b0, dlast.q_x})
                                        : $signed({1'b0, dlast.q_x});
        contact.normal_y <= dlast.neg_y ? -$signed({1'b0, dlast.q_y})
                                        : $signed({1'b0, dlast.q_y});
      end else begin
        contact.normal_x <= dlast.nx;
        contact.normal_y <= dlast.ny;
      end
    end
  end

  a_miss_clean: assert property (@(posedge clk) disable iff (rst)
    (contact.valid && !contact.hit) |->
      (contact.normal_x == 18'sd0 && contact.normal_y == 18'sd0 && contact.depth == 32'sd0))
    else $error("miss transaction carries a nonzero normal or depth");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    contact.valid |->
      (contact.normal_x <= UNIT_POS && contact.normal_x >= UNIT_NEG &&
       contact.normal_y <= UNIT_POS && contact.normal_y >= UNIT_NEG))
    else $error("normal component outside unit range");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    (adv && dsv[QUO_W-1]) |=> contact.valid)
    else $error("finished item did not reach the output register");

endmodule

`default_nettype wire

// ===== verif/spc_contact_checker.sv =====
`default_nettype none

module spc_contact_checker import spc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  spc_pair_if           pair,
  spc_contact_if        contact,
  output int            errors,
  output int            pending
);

  typedef struct packed {
    logic               hit;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic signed [31:0] depth;
  } contact_t;

  contact_t expected_contacts[$];
  int       seen_count;

  function automatic logic [65:0] floor_root(input logic [131:0] v);
    logic [131:0] rem;
    logic [131:0] r;
    logic [131:0] b;
    rem = v;
    r = '0;
    b = 132'd1 << 130;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[65:0];
  endfunction

  function automatic longint abs_l(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [131:0] length_sq(input longint u, input longint v);
    logic [131:0] ua;
    logic [131:0] va;
    ua = 132'(abs_l(u));
    va = 132'(abs_l(v));
    return ua * ua + va * va;
  endfunction

  // Component of a unit vector, truncated toward zero in magnitude.
  function automatic logic signed [17:0] unit_part(input longint c, input logic [65:0] len);
    logic [131:0] m;
    m = (132'(abs_l(c)) << 16) / 132'(len);
    return (c < 0) ? -18'(m) : 18'(m);
  endfunction

  function automatic logic signed [31:0] clamp_depth(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic contact_t predict_contact(
      input logic [1:0] op, input longint ax, input longint ay, input longint aw,
      input longint ah, input longint bx, input longint by, input longint bw,
      input longint bh);
    contact_t     c;
    longint       r, dx, dy, xo, yo, cx, cy, n, ex, ey, r2, dep;
    logic [65:0]  d;
    logic [131:0] sq;
    c = '0;
    dep = 0;
    if (op == OP_CC) begin
      r = aw + bw;
      dx = ax - bx;
      dy = ay - by;
      d = floor_root(length_sq(dx, dy));
      if (r > longint'(d)) begin
        c.hit = 1'b1;
        if (d == 0) begin
          c.nx = UNIT_POS;
          dep = aw;
        end else begin
          c.nx = unit_part(dx, d);
          c.ny = unit_part(dy, d);
          dep = r - longint'(d);
        end
      end
    end else if (op == OP_BB) begin
      // Offsets are kept in half-LSB units so box centers stay exact.
      dx = (2 * bx + bw) - (2 * ax + aw);
      dy = (2 * by + bh) - (2 * ay + ah);
      xo = (aw + bw - abs_l(dx)) / 2;
      yo = (ah + bh - abs_l(dy)) / 2;
      if (xo > 0 && yo > 0) begin
        c.hit = 1'b1;
        if (xo < yo) begin
          c.nx = (dx < 0) ? UNIT_POS : UNIT_NEG;
          dep = xo;
        end else begin
          c.ny = (dy < 0) ? UNIT_POS : UNIT_NEG;
          dep = yo;
        end
      end
    end else if (op == OP_CB) begin
      r2 = 2 * aw;
      dx = 2 * bx + bw - 2 * ax;
      dy = 2 * by + bh - 2 * ay;
      cx = (dx < -bw) ? -bw : ((dx > bw) ? bw : dx);
      cy = (dy < -bh) ? -bh : ((dy > bh) ? bh : dy);
      if (cx == dx && cy == dy) begin
        // The circle center lies inside the box: push out through the nearest face.
        c.hit = 1'b1;
        if (abs_l(dx) > abs_l(dy)) begin
          cx = (cx > 0) ? bw : -bw;
          n = dx - cx;
          c.nx = (n < 0) ? UNIT_NEG : UNIT_POS;
        end else begin
          cy = (cy > 0) ? bh : -bh;
          n = dy - cy;
          c.ny = (n < 0) ? UNIT_NEG : UNIT_POS;
        end
        if (n == 0) begin
          c.nx = UNIT_POS;
          c.ny = '0;
        end
        dep = aw - (abs_l(n) >>> 1);
      end else begin
        ex = dx - cx;
        ey = dy - cy;
        sq = length_sq(ex, ey);
        if (sq <= 132'(r2) * 132'(r2)) begin
          d = floor_root(sq);
          c.hit = 1'b1;
          c.nx = unit_part(-ex, d);
          c.ny = unit_part(-ey, d);
          dep = aw - longint'(d >> 1);
        end
      end
    end
    c.depth = clamp_depth(dep);
    return c;
  endfunction

  task automatic report(input string what);
    $display("[%0t] contact %0d: %s", $time, seen_count, what);
    errors++;
  endtask

  initial begin
    errors = 0;
    seen_count = 0;
  end

  assign pending = expected_contacts.size();

  always @(posedge clk) begin
    contact_t want;
    if (!rst && pair.valid && pair.ready) begin
      expected_contacts.push_back(predict_contact(pair.operation,
          longint'(pair.a_x), longint'(pair.a_y),
          longint'(pair.a_width_or_radius), longint'(pair.a_height),
          longint'(pair.b_x), longint'(pair.b_y),
          longint'(pair.b_width_or_radius), longint'(pair.b_height)));
    end
    if (!rst && contact.valid && contact.ready) begin
      if (expected_contacts.size() == 0) begin
        report("transaction with nothing expected");
      end else begin
        want = expected_contacts.pop_front();
        if (contact.hit !== want.hit)
          report($sformatf("hit %0b, expected %0b", contact.hit, want.hit));
        if (contact.normal_x !== want.nx)
          report($sformatf("normal_x %0d, expected %0d", contact.normal_x, want.nx));
        if (contact.normal_y !== want.ny)
          report($sformatf("normal_y %0d, expected %0d", contact.normal_y, want.ny));
        if (contact.depth !== want.depth)
          report($sformatf("depth %0d, expected %0d", contact.depth, want.depth));
      end
      seen_count++;
    end
  end

endmodule

`default_nettype wire

// ===== verif/shape_pair_contact_unit_tb.sv =====
`default_nettype none

module shape_pair_contact_unit_tb;
  import spc_pkg::*;

  localparam int ONE = 65536;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   cycles;
  bit   calm;

  spc_pair_if    pair();
  spc_contact_if contact();

  shape_pair_contact_unit dut (
    .clk(clk), .rst(rst), .pair(pair), .contact(contact)
  );

  spc_contact_checker checker_i (
    .clk(clk), .rst(rst), .pair(pair), .contact(contact),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (calm || p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver stalls: after the last one ends, a fresh stall length is drawn at random times while calm is clear.
  int stall_left;
  always @(negedge clk) begin
    if (rst) begin
      contact.ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      contact.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      contact.ready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) stall_left <= gap_len();
    end
  end

  // Sizes are passed as int and cut to the 31-bit field width here.
  task automatic send(input logic [1:0] op, input int ax, input int ay,
                      input int aw, input int ah,
                      input int bx, input int by,
                      input int bw, input int bh);
    int g;
    pair.valid <= 1'b1;
    pair.operation <= op;
    pair.a_x <= ax;
    pair.a_y <= ay;
    pair.a_width_or_radius <= 31'(aw);
    pair.a_height <= 31'(ah);
    pair.b_x <= bx;
    pair.b_y <= by;
    pair.b_width_or_radius <= 31'(bw);
    pair.b_height <= 31'(bh);
    do @(posedge clk); while (!pair.ready);
    @(negedge clk);
    g = gap_len();
    if (g > 0) begin
      pair.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  function automatic int near_coord();
    return $urandom_range(0, 8 * ONE) - 4 * ONE;
  endfunction

  function automatic int near_size();
    return int'($urandom_range(0, 3 * ONE));
  endfunction

  function automatic int any_size();
    return int'($urandom_range(0, 32'h7fffffff));
  endfunction

  initial begin
    int         n;
    logic [1:0] op;
    int         ax, ay, bx, by;
    cycles = 0;
    calm = 1'b0;
    rst = 1'b1;
    pair.valid = 1'b0;
    pair.operation = OP_CC;
    pair.a_x = '0;
    pair.a_y = '0;
    pair.a_width_or_radius = '0;
    pair.a_height = '0;
    pair.b_x = '0;
    pair.b_y = '0;
    pair.b_width_or_radius = '0;
    pair.b_height = '0;
    contact.ready = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Circle pairs: coincident centers, two zero radii, saturating depth, far miss.
    send(OP_CC, 0, 0, ONE, 0, 0, 0, 2 * ONE, 0);
    send(OP_CC, 5, 5, 0, 0, 5, 5, 0, 0);
    send(OP_CC, 0, 0, 32'h7fffffff, 0, ONE, -ONE, 32'h7fffffff, 0);
    send(OP_CC, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
         32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
    send(OP_CC, 3 * ONE, 4 * ONE, 3 * ONE, 0, 0, 0, 3 * ONE, 0);
    send(OP_CC, -ONE, 2 * ONE, ONE, 0, 0, 0, ONE, 0);
    // Box pairs: x axis least, y axis least, equal overlaps, touching only.
    send(OP_BB, 0, 0, 4 * ONE, 4 * ONE, 3 * ONE, ONE, 4 * ONE, 2 * ONE);
    send(OP_BB, 0, 0, 4 * ONE, 4 * ONE, ONE, -3 * ONE, 2 * ONE, 4 * ONE);
    send(OP_BB, 0, 0, 2 * ONE, 2 * ONE, ONE, ONE, 2 * ONE, 2 * ONE);
    send(OP_BB, 0, 0, ONE, ONE, ONE, 0, ONE, ONE);
    send(OP_BB, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
         32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
    // Circle against box: inside, on a face, on the center, outside hit and miss.
    send(OP_CB, ONE, 2 * ONE, 5 * ONE, 0, 0, 0, 4 * ONE, 4 * ONE);
    send(OP_CB, 4 * ONE, ONE, ONE, 0, 0, 0, 4 * ONE, 4 * ONE);
    send(OP_CB, 2 * ONE, 2 * ONE, 0, 0, 0, 0, 4 * ONE, 4 * ONE);
    send(OP_CB, 5 * ONE, 5 * ONE, 2 * ONE, 0, 0, 0, 4 * ONE, 4 * ONE);
    send(OP_CB, -ONE, 2 * ONE, ONE, 0, 0, 0, 4 * ONE, 4 * ONE);
    send(OP_CB, 7 * ONE, 7 * ONE, ONE, 0, 0, 0, 4 * ONE, 4 * ONE);
    send(OP_CB, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
         32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send(2'd3, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE);

    // Hold the sender until the pipeline has drained.
    pair.valid <= 1'b0;
    while (pending != 0) @(negedge clk);

    for (n = 0; n < 500; n++) begin
      if (n % 100 == 50) calm = ~calm;
      op = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      if ($urandom_range(0, 4) != 0) begin
        ax = near_coord();
        ay = near_coord();
        bx = near_coord();
        by = near_coord();
        send(op, ax, ay, near_size(), near_size(), bx, by, near_size(), near_size());
      end else begin
        send(op, $urandom, $urandom, any_size(), any_size(),
             $urandom, $urandom, any_size(), any_size());
      end
    end

    pair.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
